[hw/rtl/atf_pkg.sv]
// shared types, constants and header byte function for the transmit request framer
package atf_pkg;

	localparam int unsigned ATF_FIFO_DEPTH = 4;
	localparam int unsigned ATF_CFG_IDX_W  = 8;
	localparam int unsigned ATF_HDR_LEN    = 17;
	localparam int unsigned ATF_IDX_W      = 5;

	localparam logic [ATF_CFG_IDX_W-1:0] CFG_DEST_HIGH = 8'd0;
	localparam logic [ATF_CFG_IDX_W-1:0] CFG_DEST_LOW  = 8'd1;

	localparam logic [7:0] BYTE_DELIM    = 8'h7E;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_TYPE     = 8'h10;
	localparam logic [7:0] BYTE_FRAME_ID = 8'h01;
	localparam logic [7:0] BYTE_BCAST_HI = 8'hFF;
	localparam logic [7:0] BYTE_BCAST_LO = 8'hFE;
	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
	localparam logic [7:0] LEN_OVERHEAD  = 8'd14;

	// first byte summed into the checksum
	localparam logic [ATF_IDX_W-1:0] IDX_SUM_START = 5'd3;
	localparam logic [ATF_IDX_W-1:0] IDX_HDR_LAST  = 5'(ATF_HDR_LEN - 1);

	typedef struct packed {
		logic       first;
		logic [7:0] data;
		logic [7:0] plen;
		logic       last;
	} item_t;

	typedef enum logic [1:0] {
		BK_START,
		BK_HDR,
		BK_DATA,
		BK_CSUM
	} back_state_t;

	function automatic logic [7:0] hdr_byte(
		input logic [ATF_IDX_W-1:0] idx,
		input logic [7:0]           plen,
		input logic [31:0]          hi,
		input logic [31:0]          lo
	);
		logic [7:0] b;
		case (idx)
			5'd0:    b = BYTE_DELIM;
			5'd1:    b = BYTE_ZERO;
			5'd2:    b = plen + LEN_OVERHEAD;
			5'd3:    b = BYTE_TYPE;
			5'd4:    b = BYTE_FRAME_ID;
			5'd5:    b = hi[31:24];
			5'd6:    b = hi[23:16];
			5'd7:    b = hi[15:8];
			5'd8:    b = hi[7:0];
			5'd9:    b = lo[31:24];
			5'd10:   b = lo[23:16];
			5'd11:   b = lo[15:8];
			5'd12:   b = lo[7:0];
			5'd13:   b = BYTE_BCAST_HI;
			5'd14:   b = BYTE_BCAST_LO;
			default: b = BYTE_ZERO;
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/atf_front.sv]
// input side: accepts payload transfers and tags the first byte of each frame
module atf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     payload_byte,
	input  logic [7:0]     payload_length,
	input  logic           payload_last,
	output logic           push_valid,
	input  logic           push_ready,
	output atf_pkg::item_t push_item
);
	import atf_pkg::*;

	logic in_frame_q;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_item.first = ~in_frame_q;
		push_item.data  = payload_byte;
		push_item.plen  = payload_length;
		push_item.last  = payload_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (in_valid && push_ready) begin
			in_frame_q <= ~payload_last;
		end
	end

endmodule

[hw/rtl/atf_fifo.sv]
// small register queue between the front and back parts
module atf_fifo #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned WIDTH = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/atf_back.sv]
// output side: sequences header, payload and checksum bytes into the output register
module atf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_pop,
	input  atf_pkg::item_t item,
	input  logic [31:0]    dest_high,
	input  logic [31:0]    dest_low,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     frame_byte,
	output logic           frame_end,
	output logic           run_last
);
	import atf_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	back_state_t          phase;
	logic [ATF_IDX_W-1:0] idx_q;
	logic [ATF_IDX_W-1:0] idx_d;
	logic [ATF_IDX_W-1:0] idx_cur;
	logic [7:0]           sum_q;
	logic [7:0]           sum_d;
	logic                 advance;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic                 end_q;
	logic                 rlast_q;
	logic [7:0]           byte_d;
	logic                 end_d;
	logic                 rlast_d;

	assign advance    = item_valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign frame_end  = end_q;
	assign run_last   = rlast_q;

	always_comb begin
		phase   = state_q;
		idx_cur = idx_q;
		if (state_q == BK_START) begin
			phase   = item.first ? BK_HDR : BK_DATA;
			idx_cur = '0;
		end
		state_d  = state_q;
		idx_d    = idx_q;
		sum_d    = sum_q;
		byte_d   = BYTE_ZERO;
		end_d    = 1'b0;
		rlast_d  = 1'b0;
		item_pop = 1'b0;
		case (phase)
			BK_HDR: begin
				byte_d = hdr_byte(idx_cur, item.plen, dest_high, dest_low);
				if (idx_cur == '0) begin
					sum_d = '0;
				end else if (idx_cur >= IDX_SUM_START) begin
					sum_d = sum_q + byte_d;
				end
				idx_d   = idx_cur + 1'b1;
				state_d = (idx_cur == IDX_HDR_LAST) ? BK_DATA : BK_HDR;
			end
			BK_DATA: begin
				byte_d = item.data;
				sum_d  = sum_q + item.data;
				if (item.last) begin
					state_d = BK_CSUM;
				end else begin
					rlast_d  = 1'b1;
					item_pop = advance;
					state_d  = BK_START;
				end
			end
			BK_CSUM: begin
				byte_d   = BYTE_ALL_ONES - sum_q;
				end_d    = 1'b1;
				rlast_d  = 1'b1;
				sum_d    = '0;
				item_pop = advance;
				state_d  = BK_START;
			end
			default: begin
				state_d = BK_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_START;
			idx_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_d;
				idx_q       <= idx_d;
				sum_q       <= sum_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q  <= byte_d;
			end_q   <= end_d;
			rlast_q <= rlast_d;
		end
	end

endmodule

[hw/rtl/api_tx_request_framer.sv]
// top level of the transmit request framer: config registers, front, queue and back
// an input payload byte is written into the queue, then the back sequencer registers its output byte
// throughput: one payload byte per cycle inside a frame while the queue holds items and out_ready is high
// a frame's first byte is preceded by 17 header bytes, and its last byte is followed by the checksum byte
// the queue between front and back holds FIFO_DEPTH items so input keeps flowing until it is full
// reset: asynchronous, clears frame state, checksum, queue and destination address
module api_tx_request_framer #(
	parameter int unsigned FIFO_DEPTH = atf_pkg::ATF_FIFO_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        payload_byte,
	input  logic [7:0]                        payload_length,
	input  logic                              payload_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        frame_byte,
	output logic                              frame_end,
	output logic                              run_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [atf_pkg::ATF_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                       cfg_data
);
	import atf_pkg::*;

	logic [31:0] dest_high_q;
	logic [31:0] dest_low_q;
	logic        push_valid;
	logic        push_ready;
	item_t       push_item;
	logic        pop_valid;
	logic        pop_ready;
	item_t       pop_item;
	logic [$bits(item_t)-1:0] pop_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_high_q <= '0;
			dest_low_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEST_HIGH: dest_high_q <= cfg_data;
				CFG_DEST_LOW:  dest_low_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	atf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.payload_last   (payload_last),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	atf_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH ($bits(item_t))
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_bits)
	);

	assign pop_item = item_t'(pop_bits);

	atf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_pop   (pop_ready),
		.item       (pop_item),
		.dest_high  (dest_high_q),
		.dest_low   (dest_low_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

endmodule
